// ===== hdl/rkc_pkg.sv =====
// shared constants and types for the rgb kernel convolution block
`timescale 1ns / 1ps
package rkc_pkg;

  localparam int KROWS      = 3;
  localparam int KCOLS      = 3;
  localparam int NTAPS      = KROWS * KCOLS;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int RING_ROWS  = KROWS + KCOLS + 1;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int RING_W     = $clog2(RING_ROWS);
  localparam int WCFG_W     = 11;
  localparam int HCFG_W     = 13;
  localparam int SUM_W      = 21;
  localparam int MASK_W     = 12;
  localparam int NBANKS     = 4;
  localparam int CIDX_W     = 3;
  localparam int QBITS      = 8;

  localparam logic [CIDX_W-1:0] CFG_WIDTH  = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_HEIGHT = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_BANK0  = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_BANK1  = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_BANK2  = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_BANK3  = 3'd5;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pix_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] r;
    logic signed [SUM_W-1:0] g;
    logic signed [SUM_W-1:0] b;
    logic [MASK_W-1:0]       mask;
  } acc_t;

endpackage

// ===== hdl/rkc_cell.sv =====
// one tap cell: holds a window pixel and adds its weighted value to the passing sum
`timescale 1ns / 1ps
module rkc_cell import rkc_pkg::*; (
  input  logic              clk_i,
  input  logic              shift_i,
  input  pix_t              pix_i,
  input  logic signed [7:0] weight_i,
  input  acc_t              acc_i,
  output pix_t              pix_o,
  output acc_t              acc_o
);

  pix_t               pix_q;
  acc_t               acc_q;
  acc_t               acc_d;
  logic signed [16:0] prod_r;
  logic signed [16:0] prod_g;
  logic signed [16:0] prod_b;
  logic signed [8:0]  wext;
  logic [8:0]         wabs;

  always_comb begin
    prod_r = weight_i * $signed({1'b0, pix_q.r});
    prod_g = weight_i * $signed({1'b0, pix_q.g});
    prod_b = weight_i * $signed({1'b0, pix_q.b});
    wext   = {weight_i[7], weight_i};
    wabs   = wext[8] ? 9'(-wext) : 9'(wext);
    acc_d.r    = acc_i.r + SUM_W'(prod_r);
    acc_d.g    = acc_i.g + SUM_W'(prod_g);
    acc_d.b    = acc_i.b + SUM_W'(prod_b);
    acc_d.mask = acc_i.mask + MASK_W'(wabs);
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      pix_q <= pix_i;
    end
    acc_q <= acc_d;
  end

  assign pix_o = pix_q;
  assign acc_o = acc_q;

endmodule

// ===== hdl/rkc_div.sv =====
// iterative divider: three channel magnitudes by the weight magnitude sum, one bit a cycle
`timescale 1ns / 1ps
module rkc_div import rkc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  acc_t acc_i,
  output logic done_o,
  output pix_t q_o
);

  localparam int REM_W  = SUM_W;
  localparam int STEP_W = $clog2(QBITS);

  logic [REM_W-1:0]  rem_q [3];
  logic [QBITS-1:0]  quo_q [3];
  logic [MASK_W-1:0] mask_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q;
  logic              done_q;
  logic [REM_W-1:0]  mag [3];
  logic [REM_W-1:0]  trial;

  always_comb begin
    mag[0] = acc_i.r[SUM_W-1] ? REM_W'(-acc_i.r) : REM_W'(acc_i.r);
    mag[1] = acc_i.g[SUM_W-1] ? REM_W'(-acc_i.g) : REM_W'(acc_i.g);
    mag[2] = acc_i.b[SUM_W-1] ? REM_W'(-acc_i.b) : REM_W'(acc_i.b);
    trial  = REM_W'(mask_q) << step_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(QBITS - 1);
      end else if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mask_q <= acc_i.mask;
      for (int ch = 0; ch < 3; ch++) begin
        rem_q[ch] <= mag[ch];
        quo_q[ch] <= '0;
      end
    end else if (busy_q) begin
      for (int ch = 0; ch < 3; ch++) begin
        if (rem_q[ch] >= trial) begin
          rem_q[ch]         <= rem_q[ch] - trial;
          quo_q[ch][step_q] <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign q_o    = '{r: quo_q[0], g: quo_q[1], b: quo_q[2]};

endmodule

// ===== hdl/rgb_kernel_convolution.sv =====
// top level: line store, window read sequencer, tap cell chain, divider and output register
`timescale 1ns / 1ps
// usage
// s_axis carries items: tdata holds red, green, blue; tuser[0] is 0 for a pixel, 1 for a flush.
// m_axis carries results: tdata holds red, green, blue; tuser[0] flags an all-zero kernel,
// tlast marks the final pixel of the frame.
// cfg writes image_width (0), image_height (1) and weight banks 0 to 3 (2 to 5); write only
// while idle. a size write restarts the frame.
// an item that makes no result leaves the block idle and the input ready. an item that makes a result
// holds the input while the block reads the window (one line store read per tap), lets the
// tap cell chain settle one cell a cycle, then runs eight divider steps.
// the input is ready again once the result sits in the output register, so a stalled
// receiver only blocks the next result, not the next item.
// reset returns counters to the frame start, width and height to 1024 and weights to zero;
// the line store is not cleared and needs no clearing pass.
module rgb_kernel_convolution import rkc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [23:0]           s_axis_tdata_i,   // in_red, in_green, in_blue
  input  logic [0:0]            s_axis_tuser_i,   // req_type
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [23:0]           m_axis_tdata_o,   // out_red, out_green, out_blue
  output logic [0:0]            m_axis_tuser_o,   // zero_kernel
  output logic                  m_axis_tlast_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CIDX_W-1:0]     cfg_index_i,
  input  logic [63:0]           cfg_data_i
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_WAIT = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;
  localparam int KI_W   = $clog2(KROWS + 1);
  localparam int KJ_W   = $clog2(KCOLS + 1);
  localparam int WT_W   = $clog2(NTAPS + 2);
  localparam int K_W    = ROW_W + COL_W + 1;
  localparam int ADDR_W = RING_W + COL_W;
  localparam int DEPTH  = RING_ROWS * MAX_WIDTH;
  localparam int S_W    = ROW_W + 3;

  logic [WCFG_W-1:0] width_q;
  logic [HCFG_W-1:0] height_q;
  logic [K_W-1:0]    lag_q;
  logic [63:0]       bank_q [NBANKS];
  logic [ROW_W-1:0]  in_row_q, out_row_q, job_row_q;
  logic [COL_W-1:0]  in_col_q, out_col_q, job_col_q;
  logic [RING_W-1:0] in_ring_q, out_ring_q, job_ring_q;
  logic [K_W-1:0]    kcnt_q;
  logic              done_q;
  logic              job_last_q;
  logic              zero_q;
  logic [2:0]        state_q;
  logic [KI_W-1:0]   ti_q;
  logic [KJ_W-1:0]   tj_q;
  logic [WT_W-1:0]   wait_q;
  logic              rd_valid_q;
  pix_t              rd_data_q;
  logic              m_valid_q;
  logic [23:0]       m_data_q;
  logic              m_zero_q;
  logic              m_last_q;

  pix_t              mem [DEPTH];
  logic [ADDR_W-1:0] waddr, raddr;
  logic              wr_en;
  pix_t              in_pix;

  logic [WCFG_W-1:0] eff_w;
  logic [HCFG_W-1:0] eff_h;
  logic              accept, is_flush, emit, out_last, out_free;
  logic [NBANKS*64-1:0] wvec;

  logic [S_W-1:0]    r_s, c_s, r_cl, c_cl, dr;
  logic signed [4:0] ring_s;
  logic [RING_W-1:0] rd_ring;

  pix_t pix_c [NTAPS+1];
  acc_t acc_c [NTAPS+1];
  logic div_start, div_done;
  pix_t div_q;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign is_flush        = s_axis_tuser_i[0];
  assign in_pix          = '{r: s_axis_tdata_i[7:0], g: s_axis_tdata_i[15:8],
                             b: s_axis_tdata_i[23:16]};
  assign emit            = accept && (is_flush ? done_q : (!done_q && kcnt_q >= lag_q));
  assign out_last        = (out_row_q == ROW_W'(height_q - 1'b1))
                        && (out_col_q == COL_W'(width_q - 1'b1));
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign wr_en           = accept && !is_flush && !done_q;
  assign waddr           = {in_ring_q, in_col_q};

  always_comb begin
    eff_w = cfg_data_i[WCFG_W-1:0];
    if (eff_w == '0) eff_w = WCFG_W'(1);
    else if (eff_w > WCFG_W'(MAX_WIDTH)) eff_w = WCFG_W'(MAX_WIDTH);
    eff_h = cfg_data_i[HCFG_W-1:0];
    if (eff_h == '0) eff_h = HCFG_W'(1);
    else if (eff_h > HCFG_W'(MAX_HEIGHT)) eff_h = HCFG_W'(MAX_HEIGHT);
  end

  // window address with clamp to the edge rows and columns
  always_comb begin
    r_s = S_W'(job_row_q) + S_W'(ti_q) - S_W'(KROWS / 2);
    c_s = S_W'(job_col_q) + S_W'(tj_q) - S_W'(KCOLS / 2);
    if (r_s[S_W-1]) r_cl = '0;
    else if (r_s > S_W'(height_q - 1'b1)) r_cl = S_W'(height_q - 1'b1);
    else r_cl = r_s;
    if (c_s[S_W-1]) c_cl = '0;
    else if (c_s > S_W'(width_q - 1'b1)) c_cl = S_W'(width_q - 1'b1);
    else c_cl = c_s;
    dr     = r_cl - S_W'(job_row_q);
    ring_s = $signed({2'b00, job_ring_q}) + $signed({dr[3], dr[3:0]});
    if (ring_s < 0) rd_ring = RING_W'(ring_s + 5'(RING_ROWS));
    else if (ring_s >= 5'(RING_ROWS)) rd_ring = RING_W'(ring_s - 5'(RING_ROWS));
    else rd_ring = RING_W'(ring_s);
    raddr = {rd_ring, c_cl[COL_W-1:0]};
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[waddr] <= in_pix;
    end
    rd_data_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WCFG_W'(1024);
      height_q   <= HCFG_W'(1024);
      lag_q      <= K_W'((KROWS / 2) * 1024 + KCOLS / 2);
      for (int b = 0; b < NBANKS; b++) bank_q[b] <= '0;
      in_row_q   <= '0;
      in_col_q   <= '0;
      in_ring_q  <= '0;
      kcnt_q     <= '0;
      done_q     <= 1'b0;
      out_row_q  <= '0;
      out_col_q  <= '0;
      out_ring_q <= '0;
      state_q    <= ST_IDLE;
      ti_q       <= '0;
      tj_q       <= '0;
      wait_q     <= '0;
      rd_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      rd_valid_q <= (state_q == ST_READ);
      if (m_valid_q && m_axis_tready_i) m_valid_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (wr_en) begin
            kcnt_q <= kcnt_q + 1'b1;
            if (K_W'(in_col_q) + 1'b1 >= K_W'(width_q)) begin
              in_col_q <= '0;
              if (K_W'(in_row_q) + 1'b1 >= K_W'(height_q)) begin
                in_row_q  <= '0;
                in_ring_q <= '0;
                done_q    <= 1'b1;
                kcnt_q    <= '0;
              end else begin
                in_row_q  <= in_row_q + 1'b1;
                in_ring_q <= (in_ring_q == RING_W'(RING_ROWS - 1)) ? '0 : in_ring_q + 1'b1;
              end
            end else begin
              in_col_q <= in_col_q + 1'b1;
            end
          end
          if (emit) begin
            job_row_q  <= out_row_q;
            job_col_q  <= out_col_q;
            job_ring_q <= out_ring_q;
            job_last_q <= out_last;
            ti_q       <= '0;
            tj_q       <= '0;
            state_q    <= ST_READ;
            if (out_last) begin
              in_row_q   <= '0;
              in_col_q   <= '0;
              in_ring_q  <= '0;
              kcnt_q     <= '0;
              done_q     <= 1'b0;
              out_row_q  <= '0;
              out_col_q  <= '0;
              out_ring_q <= '0;
            end else if (K_W'(out_col_q) + 1'b1 >= K_W'(width_q)) begin
              out_col_q  <= '0;
              out_row_q  <= out_row_q + 1'b1;
              out_ring_q <= (out_ring_q == RING_W'(RING_ROWS - 1)) ? '0 : out_ring_q + 1'b1;
            end else begin
              out_col_q <= out_col_q + 1'b1;
            end
          end
        end
        ST_READ: begin
          if (tj_q == KJ_W'(KCOLS - 1)) begin
            tj_q <= '0;
            if (ti_q == KI_W'(KROWS - 1)) begin
              wait_q  <= WT_W'(NTAPS + 1);
              state_q <= ST_WAIT;
            end else begin
              ti_q <= ti_q + 1'b1;
            end
          end else begin
            tj_q <= tj_q + 1'b1;
          end
        end
        ST_WAIT: begin
          if (wait_q == '0) state_q <= ST_DIV;
          else wait_q <= wait_q - 1'b1;
        end
        ST_DIV: begin
          if (div_done) state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_WIDTH, CFG_HEIGHT: begin
            if (cfg_index_i == CFG_WIDTH) begin
              width_q <= eff_w;
              lag_q   <= K_W'(KROWS / 2) * K_W'(eff_w) + K_W'(KCOLS / 2);
            end else begin
              height_q <= eff_h;
            end
            in_row_q   <= '0;
            in_col_q   <= '0;
            in_ring_q  <= '0;
            kcnt_q     <= '0;
            done_q     <= 1'b0;
            out_row_q  <= '0;
            out_col_q  <= '0;
            out_ring_q <= '0;
          end
          CFG_BANK0: bank_q[0] <= cfg_data_i;
          CFG_BANK1: bank_q[1] <= cfg_data_i;
          CFG_BANK2: bank_q[2] <= cfg_data_i;
          CFG_BANK3: bank_q[3] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) zero_q <= (acc_c[NTAPS].mask == '0);
    if (state_q == ST_OUT && out_free) begin
      m_data_q <= zero_q ? '0 : {div_q.b, div_q.g, div_q.r};
      m_zero_q <= zero_q;
      m_last_q <= job_last_q;
    end
  end

  // tap cell chain: pixels shift in from the line store, sums ripple one cell a cycle
  assign wvec      = {bank_q[3], bank_q[2], bank_q[1], bank_q[0]};
  assign pix_c[0]  = rd_data_q;
  assign acc_c[0]  = '0;

  for (genvar k = 0; k < NTAPS; k++) begin : g_cell
    rkc_cell u_cell (
      .clk_i    (clk_i),
      .shift_i  (rd_valid_q),
      .pix_i    (pix_c[k]),
      .weight_i ($signed(wvec[(NTAPS-1-k)*8 +: 8])),
      .acc_i    (acc_c[k]),
      .pix_o    (pix_c[k+1]),
      .acc_o    (acc_c[k+1])
    );
  end

  assign div_start = (state_q == ST_WAIT) && (wait_q == '0);

  rkc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .acc_i   (acc_c[NTAPS]),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_zero_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the rgb kernel convolution block
`timescale 1ns / 1ps
module testbench;
  import rkc_pkg::*;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;
  localparam logic [CIDX_W-1:0] CFG_SPARE = 3'd6;
  localparam logic [CIDX_W-1:0] CFG_TOP   = 3'd7;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       zero_kernel;
    logic       frame_last;
  } filt_pixel_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [23:0]       s_axis_tdata_i = '0;
  logic [0:0]        s_axis_tuser_i = '0;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [23:0]       m_axis_tdata_o;
  logic [0:0]        m_axis_tuser_o;
  logic              m_axis_tlast_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CIDX_W-1:0] cfg_index_i = '0;
  logic [63:0]       cfg_data_i = '0;

  rgb_kernel_convolution DUT (.*);

  always #6 clk_i = ~clk_i;

  // prediction state
  logic [23:0]      row_ring [RING_ROWS][MAX_WIDTH];
  logic [WCFG_W-1:0] width_reg;
  logic [HCFG_W-1:0] height_reg;
  logic [63:0]      banks [NBANKS];
  int               in_row, in_col, out_row, out_col;
  bit               frame_in_done;
  filt_pixel_t      pending_pixels [$];
  int               errors = 0;
  int               items_sent = 0;
  bit               calm = 1'b0;

  function automatic int active_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return int'(width_reg);
  endfunction

  function automatic int active_height();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return int'(height_reg);
  endfunction

  function automatic int clampi(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void restart_frame();
    in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    frame_in_done = 1'b0;
  endfunction

  function automatic void filter_output();
    int w, h, r, c, wt, mask;
    int acc [3];
    logic [23:0] px;
    logic [7:0]  wbyte;
    filt_pixel_t res;
    w = active_width();
    h = active_height();
    acc = '{0, 0, 0};
    mask = 0;
    for (int i = 0; i < KROWS; i++) begin
      r = clampi(out_row - KROWS / 2 + i, h - 1);
      for (int j = 0; j < KCOLS; j++) begin
        c = clampi(out_col - KCOLS / 2 + j, w - 1);
        wbyte = banks[(i * KCOLS + j) / 8][((i * KCOLS + j) % 8) * 8 +: 8];
        wt = int'($signed(wbyte));
        px = row_ring[r % RING_ROWS][c];
        acc[0] += wt * int'(px[7:0]);
        acc[1] += wt * int'(px[15:8]);
        acc[2] += wt * int'(px[23:16]);
        mask += (wt < 0) ? -wt : wt;
      end
    end
    for (int k = 0; k < 3; k++) begin
      if (acc[k] < 0) acc[k] = -acc[k];
      acc[k] = (mask == 0) ? 0 : acc[k] / mask;
    end
    res.red = acc[0][7:0];
    res.green = acc[1][7:0];
    res.blue = acc[2][7:0];
    res.zero_kernel = (mask == 0);
    res.frame_last = (out_row == h - 1) && (out_col == w - 1);
    pending_pixels.push_back(res);
    if (res.frame_last) begin
      restart_frame();
    end else if (out_col + 1 >= w) begin
      out_col = 0;
      out_row++;
    end else begin
      out_col++;
    end
  endfunction

  function automatic void convolve_item(logic req, logic [23:0] rgb);
    int w, h, idx, lag;
    w = active_width();
    h = active_height();
    if (req == REQ_FLUSH) begin
      if (frame_in_done) filter_output();
      return;
    end
    if (frame_in_done) return;
    row_ring[in_row % RING_ROWS][in_col % MAX_WIDTH] = rgb;
    idx = in_row * w + in_col;
    lag = (KROWS / 2) * w + KCOLS / 2;
    if (in_col + 1 >= w) begin
      in_col = 0;
      if (in_row + 1 >= h) begin
        in_row = 0;
        frame_in_done = 1'b1;
      end else begin
        in_row++;
      end
    end else begin
      in_col++;
    end
    if (idx >= lag) filter_output();
  endfunction

  // receiver stalls
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 15);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    filt_pixel_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result data=%h user=%b last=%b", $time,
                 m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (m_axis_tdata_o !== {want.blue, want.green, want.red} ||
            m_axis_tuser_o[0] !== want.zero_kernel || m_axis_tlast_o !== want.frame_last) begin
          $display("%0t: mismatch expected data=%h user=%b last=%b actual data=%h user=%b last=%b",
                   $time, {want.blue, want.green, want.red}, want.zero_kernel, want.frame_last,
                   m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
          errors++;
        end
      end
    end
  end

  task automatic send_item(logic req, logic [23:0] rgb);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= req;
    s_axis_tdata_i <= rgb;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    convolve_item(req, rgb);
    items_sent++;
  endtask

  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_WIDTH: begin
        width_reg = val[WCFG_W-1:0];
        restart_frame();
      end
      CFG_HEIGHT: begin
        height_reg = val[HCFG_W-1:0];
        restart_frame();
      end
      CFG_BANK0, CFG_BANK1, CFG_BANK2, CFG_BANK3: banks[idx - CFG_BANK0] = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_kernel(logic [63:0] b0, logic [63:0] b1);
    write_reg(CFG_BANK0, b0);
    write_reg(CFG_BANK1, b1);
    write_reg(CFG_BANK2, {$urandom, $urandom});
    write_reg(CFG_BANK3, {$urandom, $urandom});
  endtask

  function automatic logic [63:0] random_bank();
    logic [63:0] v;
    for (int k = 0; k < 8; k++) begin
      case ($urandom_range(0, 5))
        0: v[k*8 +: 8] = 8'h80;
        1: v[k*8 +: 8] = 8'h7f;
        2: v[k*8 +: 8] = 8'h00;
        default: v[k*8 +: 8] = 8'($urandom);
      endcase
    end
    return v;
  endfunction

  function automatic logic [23:0] random_rgb();
    case ($urandom_range(0, 7))
      0: return 24'h000000;
      1: return 24'hffffff;
      default: return 24'($urandom);
    endcase
  endfunction

  // pixels of one frame, optionally with ignored flushes and pixels mixed in, then drain
  task automatic run_frame(int npix, bit noisy);
    for (int p = 0; p < npix; p++) begin
      if (noisy && $urandom_range(0, 9) == 0) send_item(REQ_FLUSH, random_rgb());
      send_item(REQ_PIXEL, random_rgb());
    end
    while (frame_in_done) begin
      if (noisy && $urandom_range(0, 9) == 0) send_item(REQ_PIXEL, random_rgb());
      send_item(REQ_FLUSH, random_rgb());
    end
    settle();
  endtask

  task automatic test_directed_extremes();
    write_reg(CFG_WIDTH, 64'd3);
    write_reg(CFG_HEIGHT, 64'd2);
    set_kernel(64'h8080_8080_8080_8080, 64'h8080_8080_8080_8080);
    send_item(REQ_FLUSH, 24'hffffff);
    for (int p = 0; p < 6; p++) send_item(REQ_PIXEL, (p % 2) ? 24'hffffff : 24'h000000);
    send_item(REQ_PIXEL, 24'h123456);
    while (frame_in_done) send_item(REQ_FLUSH, 24'h000000);
    settle();
    set_kernel(64'h7f7f_7f7f_7f7f_7f7f, 64'h0000_0000_0000_007f);
    run_frame(6, 1'b0);
    set_kernel(64'h0000_0000_0000_0000, 64'h7f00_0000_0000_0000);
    run_frame(6, 1'b0);
    set_kernel(64'hff01_ff01_ff01_ff01, 64'h0000_0000_0000_0080);
    write_reg(CFG_SPARE, 64'hffff_ffff_ffff_ffff);
    write_reg(CFG_TOP, 64'd0);
    run_frame(6, 1'b0);
  endtask

  // a one-pixel frame runs in full; wide and tall frames are only started: the flush must be ignored mid-frame
  task automatic test_size_extremes();
    set_kernel(random_bank(), random_bank());
    write_reg(CFG_WIDTH, 64'd0);
    write_reg(CFG_HEIGHT, 64'd0);
    run_frame(1, 1'b0);
    write_reg(CFG_WIDTH, 64'h7ff);
    write_reg(CFG_HEIGHT, 64'd1);
    for (int p = 0; p < 40; p++) send_item(REQ_PIXEL, random_rgb());
    send_item(REQ_FLUSH, random_rgb());
    settle();
    write_reg(CFG_WIDTH, 64'd1024);
    write_reg(CFG_HEIGHT, 64'd2);
    for (int p = 0; p < 20; p++) send_item(REQ_PIXEL, random_rgb());
    send_item(REQ_FLUSH, random_rgb());
    settle();
    write_reg(CFG_WIDTH, 64'd1);
    write_reg(CFG_HEIGHT, 64'h1fff);
    for (int p = 0; p < 40; p++) send_item(REQ_PIXEL, random_rgb());
    send_item(REQ_FLUSH, random_rgb());
    settle();
  endtask

  task automatic test_size_restart();
    write_reg(CFG_WIDTH, 64'd4);
    write_reg(CFG_HEIGHT, 64'd4);
    for (int p = 0; p < 9; p++) send_item(REQ_PIXEL, random_rgb());
    settle();
    write_reg(CFG_HEIGHT, 64'd3);
    run_frame(12, 1'b0);
  endtask

  task automatic test_random_frames();
    int w, h, n;
    while (items_sent < 700) begin
      if (items_sent > 600) calm = 1'b1;
      if ($urandom_range(0, 2) != 0) set_kernel(random_bank(), random_bank());
      if ($urandom_range(0, 9) == 0) set_kernel(64'd0, 64'd0);
      w = $urandom_range(1, 9);
      h = $urandom_range(1, 6);
      write_reg(CFG_WIDTH, 64'(w));
      write_reg(CFG_HEIGHT, 64'(h));
      n = w * h;
      if ($urandom_range(0, 7) == 0) begin
        for (int p = 0; p < $urandom_range(1, n); p++) send_item(REQ_PIXEL, random_rgb());
        settle();
      end else begin
        run_frame(n, $urandom_range(0, 3) == 0);
      end
    end
  endtask

  initial begin
    restart_frame();
    width_reg = 11'd1024;
    height_reg = 13'd1024;
    for (int k = 0; k < NBANKS; k++) banks[k] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    test_size_extremes();
    test_size_restart();
    test_random_frames();
    settle();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/rkc_pkg.sv
hdl/rkc_cell.sv
hdl/rkc_div.sv
hdl/rgb_kernel_convolution.sv
tb/testbench.sv
